// ----- rtl/core/prq_pkg.sv -----
// Shared types and constants for the priority ready queue.
// Payload words, ring control group, status and action codes.
// No dependencies.
package prq_pkg;

   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_ID_BITS     = 8;

   localparam int ID_FIELD_W  = 8;
   localparam int PRI_W       = 8;
   localparam int STATUS_W    = 2;
   localparam int OCC_W       = 5;

   localparam logic ACTION_INSERT = 1'b0;
   localparam logic ACTION_SELECT = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic                  action;
      logic [ID_FIELD_W-1:0] thread_id;
      logic [PRI_W-1:0]      priority_req;
   } req_type;

   typedef struct packed {
      logic [ID_FIELD_W-1:0] selected_id;
      logic                  selected_valid;
      logic [STATUS_W-1:0]   status;
      logic [OCC_W-1:0]      occupancy;
   } rsp_type;

   // Control flags from the sequencer to the entry ring
   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic rotate;
   } ring_ctl_type;

   // Sequencer status seen by the top level
   typedef struct packed {
      logic busy;
      logic done;
   } seq_stat_type;

endpackage

// ----- rtl/core/priority_ready_queue_rotate.sv -----
// Priority ready queue: insert a thread by priority, or take the head and rotate it to the tail.
// Insert walks the entries then writes the tail; select reads the head, writes it at the tail.
// One word at a time: the next word is taken the cycle after the result is parked.
// The insert cost is set by the one-entry-per-cycle walk over the single-write, single-read ring.
// Reset (synchronous, active high) clears count, head pointer, sequencer and rsp_valid;
// the entry store itself is not cleared and needs no clearing pass.
module priority_ready_queue_rotate
   import prq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int ID_BITS     = DEF_ID_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   seq_stat_type        seq_stat;
   rsp_type             seq_rsp;
   ring_ctl_type        ring_ctl;
   logic [CW-1:0]       rd_idx, wr_idx;
   logic [ID_BITS-1:0]  wr_id, rd_id;
   logic [PRI_W-1:0]    wr_pri, rd_pri;
   logic                rsp_free;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   // Output register parts the two sides: a finished word may sit here while
   // the sequencer already takes and works on the next request word.
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = seq_stat.busy;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (seq_stat.done && rsp_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = seq_rsp;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Sequencer: count, insert walk, select rotate
   prq_seq #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .rsp_free  (rsp_free),
      .seq_stat  (seq_stat),
      .rsp_word  (seq_rsp),
      .ring_ctl  (ring_ctl),
      .rd_idx    (rd_idx),
      .wr_idx    (wr_idx),
      .wr_id     (wr_id),
      .wr_pri    (wr_pri),
      .rd_id     (rd_id),
      .rd_pri    (rd_pri)
   );

   // Entry ring: store plus head pointer, positions relative to the head
   prq_ring #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_ring (
      .clock    (clock),
      .reset    (reset),
      .ring_ctl (ring_ctl),
      .rd_idx   (rd_idx),
      .wr_idx   (wr_idx),
      .wr_id    (wr_id),
      .wr_pri   (wr_pri),
      .rd_id    (rd_id),
      .rd_pri   (rd_pri)
   );

endmodule

// ----- rtl/core/prq_ring.sv -----
// Entry ring: single-port-write, single-port-read entry store with head pointer.
// Maps logical queue positions to store addresses. Uses prq_pkg.
module prq_ring
   import prq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int ID_BITS     = DEF_ID_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ring_ctl_type                         ring_ctl,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     rd_idx,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     wr_idx,
   input  logic [ID_BITS-1:0]                   wr_id,
   input  logic [PRI_W-1:0]                     wr_pri,
   output logic [ID_BITS-1:0]                   rd_id,
   output logic [PRI_W-1:0]                     rd_pri
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int SW = CW + 1;
   localparam int EW = ID_BITS + PRI_W;

   logic [EW-1:0] store [QUEUE_DEPTH];
   logic [EW-1:0] rd_word_ff;
   logic [PW-1:0] head_ff, head_in;
   logic [SW-1:0] rd_sum, wr_sum, rd_wrap, wr_wrap;
   logic [PW-1:0] rd_addr, wr_addr;

   // head + position, folded back once into the store range
   always_comb begin
      rd_sum  = SW'(head_ff) + SW'(rd_idx);
      wr_sum  = SW'(head_ff) + SW'(wr_idx);
      rd_wrap = (rd_sum >= SW'(QUEUE_DEPTH)) ? rd_sum - SW'(QUEUE_DEPTH) : rd_sum;
      wr_wrap = (wr_sum >= SW'(QUEUE_DEPTH)) ? wr_sum - SW'(QUEUE_DEPTH) : wr_sum;
      rd_addr = rd_wrap[PW-1:0];
      wr_addr = wr_wrap[PW-1:0];
   end

   always_comb begin
      head_in = head_ff;
      if (ring_ctl.rotate) begin
         head_in = (head_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
      end else begin
         head_ff <= head_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ring_ctl.wr_en) begin
         store[wr_addr] <= {wr_id, wr_pri};
      end
      if (ring_ctl.rd_en) begin
         rd_word_ff <= store[rd_addr];
      end
   end

   assign rd_id  = rd_word_ff[EW-1:PRI_W];
   assign rd_pri = rd_word_ff[PRI_W-1:0];

endmodule

// ----- rtl/core/prq_seq.sv -----
// Sequencer: walks the entry ring one position per cycle with a shared priority compare.
// Keeps the entry count and builds the response word. Uses prq_pkg, drives prq_ring.
module prq_seq
   import prq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int ID_BITS     = DEF_ID_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  req_type                          req_data,
   input  logic                             rsp_free,
   output seq_stat_type                     seq_stat,
   output rsp_type                          rsp_word,
   output ring_ctl_type                     ring_ctl,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] rd_idx,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] wr_idx,
   output logic [ID_BITS-1:0]               wr_id,
   output logic [PRI_W-1:0]                 wr_pri,
   input  logic [ID_BITS-1:0]               rd_id,
   input  logic [PRI_W-1:0]                 rd_pri
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS,
      S_SEL_RD,
      S_SEL_WR,
      S_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          rd_idx_ff, rd_idx_in;
   logic [CW-1:0]          wr_idx_ff, wr_idx_in;
   logic                   pend_ff, pend_in;
   logic                   placed_ff, placed_in;
   logic [ID_BITS-1:0]     new_id_ff, new_id_in;
   logic [PRI_W-1:0]       new_pri_ff, new_pri_in;
   logic [ID_BITS-1:0]     carry_id_ff, carry_id_in;
   logic [PRI_W-1:0]       carry_pri_ff, carry_pri_in;
   logic [ID_FIELD_W-1:0]  res_id_ff, res_id_in;
   logic                   res_valid_ff, res_valid_in;
   logic [STATUS_W-1:0]    res_status_ff, res_status_in;
   logic                   cmp_less;

   // the one shared compare: new priority strictly below the stored one
   assign cmp_less = new_pri_ff < rd_pri;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_idx_in     = rd_idx_ff;
      wr_idx_in     = wr_idx_ff;
      pend_in       = pend_ff;
      placed_in     = placed_ff;
      new_id_in     = new_id_ff;
      new_pri_in    = new_pri_ff;
      carry_id_in   = carry_id_ff;
      carry_pri_in  = carry_pri_ff;
      res_id_in     = res_id_ff;
      res_valid_in  = res_valid_ff;
      res_status_in = res_status_ff;
      ring_ctl      = '0;
      rd_idx        = rd_idx_ff;
      wr_idx        = wr_idx_ff;
      wr_id         = new_id_ff;
      wr_pri        = new_pri_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               new_id_in     = ID_BITS'(req_data.thread_id);
               new_pri_in    = req_data.priority_req;
               rd_idx_in     = '0;
               pend_in       = 1'b0;
               placed_in     = 1'b0;
               res_id_in     = '0;
               res_valid_in  = 1'b0;
               res_status_in = STATUS_OK;
               if (req_data.action == ACTION_INSERT) begin
                  if (count_ff == CW'(QUEUE_DEPTH)) begin
                     res_status_in = STATUS_FULL;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_INS;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_status_in = STATUS_EMPTY;
                     state_in      = S_DONE;
                  end else begin
                     state_in = S_SEL_RD;
                  end
               end
            end
         end

         S_INS: begin
            // retire the entry read last cycle: place the new one or push the carry on
            if (pend_ff) begin
               if (placed_ff) begin
                  ring_ctl.wr_en = 1'b1;
                  wr_idx         = wr_idx_ff;
                  wr_id          = carry_id_ff;
                  wr_pri         = carry_pri_ff;
                  carry_id_in    = rd_id;
                  carry_pri_in   = rd_pri;
               end else if (cmp_less) begin
                  ring_ctl.wr_en = 1'b1;
                  wr_idx         = wr_idx_ff;
                  carry_id_in    = rd_id;
                  carry_pri_in   = rd_pri;
                  placed_in      = 1'b1;
               end
            end
            if (rd_idx_ff < count_ff) begin
               ring_ctl.rd_en = 1'b1;
               rd_idx         = rd_idx_ff;
               wr_idx_in      = rd_idx_ff;
               rd_idx_in      = CW'(rd_idx_ff + 1'b1);
               pend_in        = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  // tail write: carried entry, or the new one if nothing was greater
                  ring_ctl.wr_en = 1'b1;
                  wr_idx         = count_ff;
                  wr_id          = placed_ff ? carry_id_ff : new_id_ff;
                  wr_pri         = placed_ff ? carry_pri_ff : new_pri_ff;
                  count_in       = CW'(count_ff + 1'b1);
                  state_in       = S_DONE;
               end
            end
         end

         S_SEL_RD: begin
            ring_ctl.rd_en = 1'b1;
            rd_idx         = '0;
            state_in       = S_SEL_WR;
         end

         S_SEL_WR: begin
            // head goes to the tail slot, then the head pointer steps on
            ring_ctl.wr_en  = 1'b1;
            ring_ctl.rotate = 1'b1;
            wr_idx          = count_ff;
            wr_id           = rd_id;
            wr_pri          = rd_pri;
            res_id_in       = ID_FIELD_W'(rd_id);
            res_valid_in    = 1'b1;
            res_status_in   = STATUS_OK;
            state_in        = S_DONE;
         end

         S_DONE: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         pend_ff   <= 1'b0;
         placed_ff <= 1'b0;
         rd_idx_ff <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pend_ff   <= pend_in;
         placed_ff <= placed_in;
         rd_idx_ff <= rd_idx_in;
      end
      wr_idx_ff     <= wr_idx_in;
      new_id_ff     <= new_id_in;
      new_pri_ff    <= new_pri_in;
      carry_id_ff   <= carry_id_in;
      carry_pri_ff  <= carry_pri_in;
      res_id_ff     <= res_id_in;
      res_valid_ff  <= res_valid_in;
      res_status_ff <= res_status_in;
   end

   assign seq_stat.busy = (state_ff != S_IDLE);
   assign seq_stat.done = (state_ff == S_DONE);

   assign rsp_word.selected_id    = res_id_ff;
   assign rsp_word.selected_valid = res_valid_ff;
   assign rsp_word.status         = res_status_ff;
   assign rsp_word.occupancy      = OCC_W'(count_ff);

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("entry count above queue depth");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS) |-> (rd_idx_ff <= count_ff))
      else $error("insert walk ran past the tail");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS && state_in == S_DONE) |=> (count_ff == CW'($past(count_ff) + 1'b1)))
      else $error("insert completed without growing the queue");

   a_select_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && res_valid_ff) |-> (res_status_ff == STATUS_OK && count_ff != '0))
      else $error("selected word with bad status or empty queue");

endmodule
